// ===== hw/rtl/nll_pkg.sv =====
// Package for the numeric literal lexer: state codes, token kinds, character classes.
`timescale 1ns / 1ps
`default_nettype none
package nll_pkg;

  // Recognizer states, one-hot.
  typedef enum logic [18:0] {
    ST_NULL         = 19'h00001,
    ST_ZERO         = 19'h00002,
    ST_DEC          = 19'h00004,
    ST_DEC_SEP      = 19'h00008,
    ST_BIN_INC      = 19'h00010,
    ST_BIN          = 19'h00020,
    ST_BIN_SEP      = 19'h00040,
    ST_HEX_INC      = 19'h00080,
    ST_HEX          = 19'h00100,
    ST_HEX_SEP      = 19'h00200,
    ST_FRAC_INC     = 19'h00400,
    ST_WHOLE_FLT    = 19'h00800,
    ST_FLT          = 19'h01000,
    ST_FLT_SEP      = 19'h02000,
    ST_EXP_INC      = 19'h04000,
    ST_EXP_SIGN_INC = 19'h08000,
    ST_EXP          = 19'h10000,
    ST_EXP_SEP      = 19'h20000,
    ST_INVALID      = 19'h40000
  } st_t;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_BAD   = 2'd2,
    KIND_RANGE = 2'd3
  } kind_t;

  // Token produced by the recognizer in the cycle an item is stepped.
  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [31:0] value;
    logic        two31;
  } tok_t;

  localparam int unsigned AccW = 33;
  localparam logic [AccW-1:0] DEC_LIMIT = 33'h0_8000_0000;
  localparam logic [AccW-1:0] SAT_VALUE = 33'h1_0000_0000;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UZ     = 8'h5a;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_LZ     = 8'h7a;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UA) && (c <= CH_UZ);
  endfunction

  function automatic logic is_alp(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || is_upper(c);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dig(c) || ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  endfunction

  function automatic logic is_bin(input logic [7:0] c);
    return (c == CH_ZERO) || (c == CH_ONE);
  endfunction

  function automatic logic [7:0] low_case(input logic [7:0] c);
    return is_upper(c) ? (c | 8'h20) : c;
  endfunction

  // Digit weight of a decimal or hex digit character.
  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] t;
    t = is_dig(c) ? (c - CH_ZERO) : (low_case(c) - CH_LA + 8'd10);
    return t[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/nll_fsm.sv =====
// Recognizer state machine and integer accumulator for the numeric literal lexer.
`timescale 1ns / 1ps
`default_nettype none
module nll_fsm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic [7:0]     ch,
  input  logic [7:0]     la,
  output nll_pkg::tok_t  tok
);
  import nll_pkg::*;

  st_t             state_r, state_nxt;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic            ovf_r, ovf_nxt;

  st_t             n;
  logic            fin;
  logic            dd;
  logic [7:0]      lc;
  logic [3:0]      dv;
  logic [AccW+4:0] scaled;
  logic [AccW+4:0] sum;
  logic            acc_dec, acc_bin, acc_hex;
  logic            int_s, dec_s, too_big;

  always_comb begin
    n   = state_r;
    fin = 1'b0;
    lc  = low_case(ch);
    dd  = (la == CH_DOT);
    unique case (state_r)
      ST_NULL: begin
        if (ch == CH_ZERO) n = ST_ZERO;
        else if (ch == CH_DOT) n = ST_FRAC_INC;
        else if (is_dig(ch)) n = ST_DEC;
        else n = ST_INVALID;
      end
      ST_ZERO: begin
        if (lc == CH_LX) n = ST_HEX_INC;
        else if (lc == CH_LB) n = ST_BIN_INC;
        else if (ch == CH_DOT) begin
          if (dd) fin = 1'b1;
          else n = ST_FLT;
        end
        else if (lc == CH_LE) n = ST_EXP_INC;
        else if (is_dig(ch)) n = ST_DEC;
        else if (is_alp(ch)) n = ST_INVALID;
        else fin = 1'b1;
      end
      ST_DEC: begin
        if (ch == CH_DOT) begin
          if (dd) fin = 1'b1;
          else n = ST_WHOLE_FLT;
        end
        else if (lc == CH_LE) n = ST_EXP_INC;
        else if (is_alp(ch)) n = ST_INVALID;
        else if (ch == CH_USCORE) n = ST_DEC_SEP;
        else if (!is_dig(ch)) fin = 1'b1;
      end
      ST_DEC_SEP: n = is_dig(ch) ? ST_DEC : ST_INVALID;
      ST_BIN_INC, ST_BIN_SEP: n = is_bin(ch) ? ST_BIN : ST_INVALID;
      ST_BIN: begin
        if (!is_bin(ch)) begin
          if (is_alp(ch) || is_dig(ch)) n = ST_INVALID;
          else if (ch == CH_USCORE) n = ST_BIN_SEP;
          else if (ch == CH_DOT) begin
            if (dd) fin = 1'b1;
            else n = ST_INVALID;
          end
          else fin = 1'b1;
        end
      end
      ST_HEX_INC, ST_HEX_SEP: n = is_hex(ch) ? ST_HEX : ST_INVALID;
      ST_HEX: begin
        if (!is_hex(ch)) begin
          if (is_alp(ch)) n = ST_INVALID;
          else if (ch == CH_USCORE) n = ST_HEX_SEP;
          else if (ch == CH_DOT) begin
            if (dd) fin = 1'b1;
            else n = ST_INVALID;
          end
          else fin = 1'b1;
        end
      end
      ST_FRAC_INC, ST_FLT_SEP: n = is_dig(ch) ? ST_FLT : ST_INVALID;
      ST_EXP_SIGN_INC, ST_EXP_SEP: n = is_dig(ch) ? ST_EXP : ST_INVALID;
      ST_WHOLE_FLT, ST_FLT: begin
        if (lc == CH_LE) n = ST_EXP_INC;
        else if (is_alp(ch)) n = ST_INVALID;
        else if (ch == CH_USCORE) n = (state_r == ST_FLT) ? ST_FLT_SEP : ST_INVALID;
        else if (ch == CH_DOT) begin
          if (dd) fin = 1'b1;
          else n = ST_INVALID;
        end
        else if (is_dig(ch)) n = ST_FLT;
        else fin = 1'b1;
      end
      ST_EXP_INC: begin
        if ((ch == CH_PLUS) || (ch == CH_MINUS)) n = ST_EXP_SIGN_INC;
        else if (is_dig(ch)) n = ST_EXP;
        else n = ST_INVALID;
      end
      ST_EXP: begin
        if (is_alp(ch)) n = ST_INVALID;
        else if (ch == CH_USCORE) n = ST_EXP_SEP;
        else if (ch == CH_DOT) begin
          if (dd) fin = 1'b1;
          else n = ST_INVALID;
        end
        else if (!is_dig(ch)) fin = 1'b1;
      end
      default: n = ST_INVALID;
    endcase
  end

  // Accumulate one digit: value * base + digit, saturating at 2^32.
  always_comb begin
    acc_dec = (n == ST_DEC);
    acc_bin = (n == ST_BIN);
    acc_hex = (n == ST_HEX);
    dv      = digit_val(ch);
    if (acc_dec) scaled = {2'b0, acc_r, 3'b0} + {4'b0, acc_r, 1'b0};
    else if (acc_bin) scaled = {4'b0, acc_r, 1'b0};
    else scaled = {1'b0, acc_r, 4'b0};
    sum = scaled + {{(AccW+1){1'b0}}, dv};
    ovf_nxt = ovf_r;
    acc_nxt = acc_r;
    if (acc_dec || acc_bin || acc_hex) begin
      if (sum[AccW+4:AccW-1] != '0) begin
        ovf_nxt = 1'b1;
        acc_nxt = SAT_VALUE;
      end else begin
        acc_nxt = sum[AccW-1:0];
      end
    end
  end

  // Token for a literal that ends or turns invalid in this step.
  always_comb begin
    int_s   = (state_r == ST_ZERO) || (state_r == ST_DEC) ||
              (state_r == ST_BIN) || (state_r == ST_HEX);
    dec_s   = (state_r == ST_ZERO) || (state_r == ST_DEC);
    too_big = ovf_r || (dec_s ? (acc_r > DEC_LIMIT) : acc_r[AccW-1]);
    tok.emit  = fin || (n == ST_INVALID);
    tok.kind  = KIND_BAD;
    tok.value = '0;
    tok.two31 = 1'b0;
    if (fin) begin
      if (!int_s) begin
        tok.kind = KIND_FLOAT;
      end else if (too_big) begin
        tok.kind = KIND_RANGE;
      end else begin
        tok.kind  = KIND_INT;
        tok.value = acc_r[31:0];
        tok.two31 = dec_s && (acc_r == DEC_LIMIT);
      end
    end
    state_nxt = tok.emit ? ST_NULL : n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_NULL;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
      acc_r   <= tok.emit ? '0 : acc_nxt;
      ovf_r   <= tok.emit ? 1'b0 : ovf_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/numeric_literal_lexer_unit.sv =====
// Top level of the numeric literal lexer: input register, recognizer, result register.
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake             Item fields
// in_       in         in_valid / in_stall   in_char_in[7:0], in_lookahead_char[7:0]
// out_      out        out_valid / out_stall out_token_kind[1:0], out_int_value[31:0],
//                                            out_is_two_pow_31, out_char_consumed
//
// One item is accepted per clock while in_stall is low. After its acceptance an item sits in the
// input register until the recognizer steps on it, and a token it produces is loaded into
// the result register at that step: out_valid rises in the cycle after the recognizer steps
// on the closing item.
// rst_n is synchronous and returns the recognizer to its start state with an empty
// output. A stall on out_ holds the result register and, only if the input register
// is also full, raises in_stall; items that end no literal still need the output free.
module numeric_literal_lexer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic [7:0]  in_lookahead_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_token_kind,
  output logic [31:0] out_int_value,
  output logic        out_is_two_pow_31,
  output logic        out_char_consumed
);
  import nll_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  char_r;
  logic [7:0]  la_r;
  logic        out_vld_r, out_vld_nxt;
  kind_t       kind_r;
  logic [31:0] value_r;
  logic        two31_r;

  logic        go;
  logic        step;
  tok_t        tok;

  // The result slot can take a new token when it is empty or being drained.
  assign go       = !out_vld_r || !out_stall;
  assign step     = in_vld_r && go;
  assign in_stall = in_vld_r && !go;

  nll_fsm u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (char_r),
    .la    (la_r),
    .tok   (tok)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (!in_stall) in_vld_nxt = in_valid;
    out_vld_nxt = out_vld_r;
    if (step) out_vld_nxt = tok.emit;
    else if (!out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char_in;
      la_r   <= in_lookahead_char;
    end
    if (step && tok.emit) begin
      kind_r  <= tok.kind;
      value_r <= tok.value;
      two31_r <= tok.two31;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_token_kind    = kind_r;
  assign out_int_value     = value_r;
  assign out_is_two_pow_31 = two31_r;
  // A token is only produced by the character that ends the literal, which stays
  // in the stream.
  assign out_char_consumed = 1'b0;

endmodule
`default_nettype wire
